/* rtl/eam_pkg.sv */
package eam_pkg;

    // Table geometry
    localparam int TableEntries = 16;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int CntW = $clog2(TableEntries + 1);

    // Field widths
    localparam int ActW  = 2;
    localparam int CpuW  = 4;
    localparam int AddrW = 32;
    localparam int WordW = AddrW - 2;
    localparam int CfgW  = 5;
    localparam int CmpW  = (CntW > CfgW) ? CntW : CfgW;

    // Reset value of the cpu count register
    localparam logic [CfgW-1:0] CpuCountReset = CfgW'(1);

    // Action codes
    localparam logic [ActW-1:0] ActMark  = 2'd0;
    localparam logic [ActW-1:0] ActTest  = 2'd1;
    localparam logic [ActW-1:0] ActClear = 2'd2;

    // One reservation
    typedef struct packed {
        logic [WordW-1:0] word;
        logic [CpuW-1:0]  owner;
    } t_entry;

    // Table port request: one write and one read address per cycle
    typedef struct packed {
        logic             we;
        logic [IdxW-1:0]  waddr;
        t_entry           wdata;
        logic [IdxW-1:0]  raddr;
    } t_mem_req;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic            busy;
        logic [CntW-1:0] count;
    } t_status;

endpackage

/* rtl/eam_table.sv */
module eam_table (
    input  logic              i_clk,
    input  eam_pkg::t_mem_req i_req,
    output eam_pkg::t_entry   o_rdata
);

    // Reservation storage, contents undefined until written
    eam_pkg::t_entry mem [eam_pkg::TableEntries];
    eam_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/eam_ctrl.sv */
module eam_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [eam_pkg::CfgW-1:0]    i_cpu_count,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [eam_pkg::ActW-1:0]    i_action,
    input  logic [eam_pkg::CpuW-1:0]    i_cpu,
    input  logic [eam_pkg::AddrW-1:0]   i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_store_fails,
    output logic                        o_over_cpu_warning,
    output logic                        o_clear_not_found,
    output logic                        o_table_full_drop,
    output eam_pkg::t_mem_req           o_req,
    input  eam_pkg::t_entry             i_rdata,
    output eam_pkg::t_status            o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_RESOLVE,
        S_SHIFT,
        S_MOVE,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [eam_pkg::CntW-1:0]    r_count;
    logic [eam_pkg::CntW-1:0]    r_idx;
    logic [eam_pkg::ActW-1:0]    r_action;
    logic [eam_pkg::CpuW-1:0]    r_cpu;
    logic [eam_pkg::WordW-1:0]   r_word;
    logic [eam_pkg::CpuW-1:0]    r_owner;
    logic                        r_found;
    logic                        r_fails;
    logic                        r_warn;
    logic                        r_miss;
    logic                        r_drop;
    logic                        r_out_valid;
    logic                        r_out_fails;
    logic                        r_out_warn;
    logic                        r_out_miss;
    logic                        r_out_drop;

    logic [eam_pkg::CntW-1:0]    idx_next;
    logic [eam_pkg::CntW-1:0]    count_inc;
    logic                        table_full;
    logic                        mark_add;
    logic                        in_fire;

    assign idx_next   = r_idx + eam_pkg::CntW'(1);
    assign count_inc  = r_count + eam_pkg::CntW'(1);
    assign table_full = (r_count == eam_pkg::CntW'(eam_pkg::TableEntries));
    assign mark_add   = (r_state == S_RESOLVE) && (r_action == eam_pkg::ActMark)
                        && !r_found && !table_full;
    assign in_fire    = i_in_valid && o_in_ready;

    // Table port: scan reads, clear moves entries down, mark appends
    always_comb begin
        o_req.we         = 1'b0;
        o_req.waddr      = r_count[eam_pkg::IdxW-1:0];
        o_req.wdata.word = r_word;
        o_req.wdata.owner = r_cpu;
        o_req.raddr      = r_idx[eam_pkg::IdxW-1:0];
        case (r_state)
            S_RESOLVE: begin
                o_req.we = mark_add;
            end
            S_SHIFT: begin
                o_req.raddr = idx_next[eam_pkg::IdxW-1:0];
            end
            S_MOVE: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx[eam_pkg::IdxW-1:0];
                o_req.wdata = i_rdata;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE keeps the slot full on its own
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_action <= i_action;
                        r_cpu    <= i_cpu;
                        r_word   <= i_address[eam_pkg::AddrW-1:2];
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_fails  <= 1'b0;
                        r_warn   <= 1'b0;
                        r_miss   <= 1'b0;
                        r_drop   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                // Walk valid entries, one compare per read
                S_SCAN: begin
                    if (r_idx == r_count) begin
                        r_state <= S_RESOLVE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (i_rdata.word == r_word) begin
                        r_found <= 1'b1;
                        r_owner <= i_rdata.owner;
                        r_state <= S_RESOLVE;
                    end else begin
                        r_idx   <= idx_next;
                        r_state <= S_SCAN;
                    end
                end
                S_RESOLVE: begin
                    r_state <= S_DONE;
                    case (r_action)
                        eam_pkg::ActMark: begin
                            if (!r_found) begin
                                if (table_full) begin
                                    r_drop <= 1'b1;
                                end else begin
                                    r_count <= count_inc;
                                    r_warn  <= eam_pkg::CmpW'(count_inc)
                                               > eam_pkg::CmpW'(i_cpu_count);
                                end
                            end
                        end
                        eam_pkg::ActTest: begin
                            r_fails <= !r_found || (r_owner != r_cpu);
                        end
                        eam_pkg::ActClear: begin
                            if (!r_found) begin
                                r_miss <= 1'b1;
                            end else begin
                                r_state <= S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // Close the gap left by a cleared entry
                S_SHIFT: begin
                    if (idx_next >= r_count) begin
                        r_count <= r_count - eam_pkg::CntW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_idx   <= idx_next;
                    r_state <= S_SHIFT;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_fails <= r_fails;
                        r_out_warn  <= r_warn;
                        r_out_miss  <= r_miss;
                        r_out_drop  <= r_drop;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_store_fails      = r_out_fails;
    assign o_over_cpu_warning = r_out_warn;
    assign o_clear_not_found  = r_out_miss;
    assign o_table_full_drop  = r_out_drop;
    assign o_status.busy      = (r_state != S_IDLE);
    assign o_status.count     = r_count;

endmodule

/* rtl/exclusive_access_monitor.sv */
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_action, i_cpu, i_address
// out       output     o_out_valid / i_out_ready  o_store_fails, o_over_cpu_warning,
//                                                 o_clear_not_found, o_table_full_drop
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (cpu_count)
//
// One transaction at a time; a single comparator walks the table, reading and then
// comparing each entry. A transaction is accepted, scans entries until one matches or
// all n have been read, is resolved, and loads its result into the output register.
// A clear that hits then moves each later entry down one place (read, write).
// Synchronous active-low reset empties the table and sets cpu_count to 1.
// A stalled result holds in the output register; the next transaction waits at its end.
module exclusive_access_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [eam_pkg::CfgW-1:0]    i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [eam_pkg::ActW-1:0]    i_action,
    input  logic [eam_pkg::CpuW-1:0]    i_cpu,
    input  logic [eam_pkg::AddrW-1:0]   i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_store_fails,
    output logic                        o_over_cpu_warning,
    output logic                        o_clear_not_found,
    output logic                        o_table_full_drop
);

    logic [eam_pkg::CfgW-1:0] r_cpu_count;
    eam_pkg::t_mem_req        req;
    eam_pkg::t_entry          rdata;
    eam_pkg::t_status         status;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= eam_pkg::CpuCountReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cpu_count <= i_cfg_data;
        end
    end

    eam_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cpu_count        (r_cpu_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_cpu              (i_cpu),
        .i_address          (i_address),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_store_fails      (o_store_fails),
        .o_over_cpu_warning (o_over_cpu_warning),
        .o_clear_not_found  (o_clear_not_found),
        .o_table_full_drop  (o_table_full_drop),
        .o_req              (req),
        .i_rdata            (rdata),
        .o_status           (status)
    );

    eam_table u_table (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    // Entry count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= eam_pkg::CntW'(eam_pkg::TableEntries))
        else $error("entry count above table size");

    // At most one flag per result
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_store_fails, o_over_cpu_warning,
                                  o_clear_not_found, o_table_full_drop}))
        else $error("more than one result flag set");

    // An accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (status.busy && !o_in_ready))
        else $error("block not busy after accepting a transaction");

    // Count changes only while working on a transaction
    a_count_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.busy |=> $stable(status.count))
        else $error("entry count changed while idle");

endmodule
